// ===== sv/lswc_pkg.sv =====
`timescale 1ns / 1ps
package lswc_pkg;

	// Outcode bits, one for each window edge.
	localparam logic [3:0] CODE_LEFT   = 4'h1;
	localparam logic [3:0] CODE_RIGHT  = 4'h2;
	localparam logic [3:0] CODE_BOTTOM = 4'h4;
	localparam logic [3:0] CODE_TOP    = 4'h8;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_LEFT   = 2'd0;
	localparam logic [1:0] REG_BOTTOM = 2'd1;
	localparam logic [1:0] REG_RIGHT  = 2'd2;
	localparam logic [1:0] REG_TOP    = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	// Control that travels alongside the data through the divider cells.
	typedef struct packed {
		logic vld;
		logic neg;
		logic zero;
	} div_ctl_t;

endpackage

// ===== sv/lswc_div_cell.sv =====
`timescale 1ns / 1ps
module lswc_div_cell #(
	parameter int N = 16,
	parameter int P = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lswc_pkg::div_ctl_t prev_ctl,
	input  logic [P-1:0]      prev_num,
	input  logic [N-1:0]      prev_rem,
	input  logic [N-1:0]      prev_den,
	input  logic [N-1:0]      prev_quo,
	output lswc_pkg::div_ctl_t next_ctl,
	output logic [P-1:0]      next_num,
	output logic [N-1:0]      next_rem,
	output logic [N-1:0]      next_den,
	output logic [N-1:0]      next_quo
);
	import lswc_pkg::*;

	logic [N:0]   trial;
	logic [N:0]   diff;
	logic         ge;
	div_ctl_t     ctl_q;
	logic [P-1:0] num_q;
	logic [N-1:0] rem_q;
	logic [N-1:0] den_q;
	logic [N-1:0] quo_q;

	// One restoring step: bring down the next dividend bit and try the divisor.
	always_comb begin
		trial = {prev_rem, prev_num[P-1]};
		diff  = trial - {1'b0, prev_den};
		ge    = (trial >= {1'b0, prev_den});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= prev_ctl;
		end
	end

	always_ff @(posedge clk) begin
		num_q <= {prev_num[P-2:0], 1'b0};
		rem_q <= ge ? diff[N-1:0] : trial[N-1:0];
		den_q <= prev_den;
		quo_q <= {prev_quo[N-2:0], ge};
	end

	assign next_ctl = ctl_q;
	assign next_num = num_q;
	assign next_rem = rem_q;
	assign next_den = den_q;
	assign next_quo = quo_q;

endmodule

// ===== sv/lswc_div_chain.sv =====
`timescale 1ns / 1ps
module lswc_div_chain #(
	parameter int N = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lswc_pkg::div_ctl_t start_ctl,
	input  logic [2*N-1:0]     start_num,
	input  logic [N-1:0]       start_den,
	output lswc_pkg::div_ctl_t done_ctl,
	output logic [N-1:0]       done_quo
);
	import lswc_pkg::*;

	localparam int P = 2 * N;

	div_ctl_t     ctl [P+1];
	logic [P-1:0] num [P+1];
	logic [N-1:0] rem [P+1];
	logic [N-1:0] den [P+1];
	logic [N-1:0] quo [P+1];

	assign ctl[0] = start_ctl;
	assign num[0] = start_num;
	assign rem[0] = '0;
	assign den[0] = start_den;
	assign quo[0] = '0;

	// One cell per quotient bit; only the low N quotient bits are kept.
	for (genvar g = 0; g < P; g++) begin : g_cell
		lswc_div_cell #(.N(N), .P(P)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.prev_ctl (ctl[g]),
			.prev_num (num[g]),
			.prev_rem (rem[g]),
			.prev_den (den[g]),
			.prev_quo (quo[g]),
			.next_ctl (ctl[g+1]),
			.next_num (num[g+1]),
			.next_rem (rem[g+1]),
			.next_den (den[g+1]),
			.next_quo (quo[g+1])
		);
	end

	assign done_ctl = ctl[P];
	assign done_quo = ctl[P].zero ? '0 : quo[P];

endmodule

// ===== sv/line_segment_window_clip_top.sv =====
`timescale 1ns / 1ps
// A segment accepted or rejected outright passes the evaluate and output states;
// each clip round, at most MAX_CLIP_ROUNDS of them, adds a multiply step and a
// pass through the divider chain of 2*COORD_BITS cells.
// Throughput: one segment at a time; the next item is taken once the result
// of the previous one sits in the output register.
// Reset: arst_n clears the window to zero and empties the control path.
module line_segment_window_clip_top #(
	parameter int COORD_BITS      = 16,
	parameter int MAX_CLIP_ROUNDS = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [3:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         seg_valid,
	output logic                         seg_stall,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic                         visible,
	output logic signed [COORD_BITS-1:0] out_first_x,
	output logic signed [COORD_BITS-1:0] out_first_y,
	output logic signed [COORD_BITS-1:0] out_second_x,
	output logic signed [COORD_BITS-1:0] out_second_y
);
	import lswc_pkg::*;

	localparam int N  = COORD_BITS;
	localparam int RW = $clog2(MAX_CLIP_ROUNDS + 1);

	// Window registers, written over the configuration port.
	logic signed [N-1:0] wl_q, wb_q, wr_q, wt_q;

	// Working endpoints; the first one is always the one being clipped.
	logic signed [N-1:0] x0_q, y0_q, x1_q, y1_q;
	logic [RW-1:0]       round_q;
	logic                upd_y_q;
	logic signed [N-1:0] base_q;

	// Divider operands, signed, and their registered product.
	logic signed [N:0]   op_a_q, op_b_q, op_c_q;
	div_ctl_t            start_q;
	logic [2*N-1:0]      prod_q;
	logic [N-1:0]        den_q;

	state_t state_q, state_d;

	logic                res_valid_q, vis_q;
	logic signed [N-1:0] ofx_q, ofy_q, osx_q, osy_q;

	logic [3:0]          c0, c1, sc0;
	logic signed [N-1:0] sx0, sy0, sx1, sy1;
	logic [N-1:0]        mag_a, mag_b, mag_c;
	div_ctl_t            done_ctl;
	logic [N-1:0]        done_quo;
	logic [N-1:0]        q_signed;
	logic signed [N-1:0] new_coord;
	logic                cfg_wr;
	logic                out_take;
	logic                load_out;
	logic                vis_d;

	function automatic logic [3:0] encode(input logic signed [N-1:0] x,
			input logic signed [N-1:0] y);
		logic [3:0] code;
		code = '0;
		if (x < wl_q) begin
			code = code | CODE_LEFT;
		end else if (x > wr_q) begin
			code = code | CODE_RIGHT;
		end
		if (y < wb_q) begin
			code = code | CODE_BOTTOM;
		end else if (y > wt_q) begin
			code = code | CODE_TOP;
		end
		return code;
	endfunction

	function automatic logic [N-1:0] mag(input logic signed [N:0] v);
		logic [N:0] t;
		t = v[N] ? -v : v;
		return t[N-1:0];
	endfunction

	// Configuration port: writes land in the access phase, reads are plain muxing.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= '0;
			wb_q <= '0;
			wr_q <= '0;
			wt_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_LEFT:   wl_q <= pwdata[N-1:0];
				REG_BOTTOM: wb_q <= pwdata[N-1:0];
				REG_RIGHT:  wr_q <= pwdata[N-1:0];
				REG_TOP:    wt_q <= pwdata[N-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_LEFT:   prdata = 32'(wl_q);
			REG_BOTTOM: prdata = 32'(wb_q);
			REG_RIGHT:  prdata = 32'(wr_q);
			REG_TOP:    prdata = 32'(wt_q);
			default:    prdata = '0;
		endcase
	end

	// Outcodes of the current endpoints, and the endpoints after the swap that
	// brings the outside point to the front.
	always_comb begin
		c0  = encode(x0_q, y0_q);
		c1  = encode(x1_q, y1_q);
		sx0 = (c0 == '0) ? x1_q : x0_q;
		sy0 = (c0 == '0) ? y1_q : y0_q;
		sx1 = (c0 == '0) ? x0_q : x1_q;
		sy1 = (c0 == '0) ? y0_q : y1_q;
		sc0 = (c0 == '0) ? c1 : c0;
	end

	always_comb begin
		mag_a = mag(op_a_q);
		mag_b = mag(op_b_q);
		mag_c = mag(op_c_q);
	end

	lswc_div_chain #(.N(N)) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.start_ctl (start_q),
		.start_num (prod_q),
		.start_den (den_q),
		.done_ctl  (done_ctl),
		.done_quo  (done_quo)
	);

	// The clipped coordinate is the opposite-axis value plus the signed quotient.
	always_comb begin
		q_signed  = done_ctl.neg ? -done_quo : done_quo;
		new_coord = base_q + signed'(q_signed);
	end

	assign out_take = res_valid_q & ~res_stall;

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		vis_d    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (seg_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (c0 == '0 && c1 == '0) begin
					state_d = ST_OUT;
				end else if ((c0 & c1) != '0) begin
					state_d = ST_OUT;
				end else if (round_q >= RW'(MAX_CLIP_ROUNDS)) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_DIV;
			ST_DIV: begin
				if (done_ctl.vld) begin
					state_d = ST_EVAL;
				end
			end
			ST_OUT: begin
				vis_d = (c0 == '0) && (c1 == '0);
				if (!res_valid_q || out_take) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			round_q     <= '0;
			start_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= '0;
			if (state_q == ST_IDLE) begin
				round_q <= '0;
			end else if (state_q == ST_DIV && done_ctl.vld) begin
				round_q <= round_q + 1'b1;
			end
			if (state_q == ST_MUL) begin
				start_q.vld  <= 1'b1;
				start_q.neg  <= op_a_q[N] ^ op_b_q[N] ^ op_c_q[N];
				start_q.zero <= (mag_c == '0);
			end
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (out_take) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x0_q <= start_x;
				y0_q <= start_y;
				x1_q <= end_x;
				y1_q <= end_y;
			end
			ST_EVAL: begin
				// The swap is committed only when a clip round follows; a finished
				// segment is not swapped, so outputs keep the order.
				if (state_d == ST_MUL) begin
					x0_q <= sx0;
					y0_q <= sy0;
					x1_q <= sx1;
					y1_q <= sy1;
				end
				if ((sc0 & CODE_LEFT) != '0) begin
					op_a_q  <= (N+1)'(wl_q) - (N+1)'(sx0);
					op_b_q  <= (N+1)'(sy1) - (N+1)'(sy0);
					op_c_q  <= (N+1)'(sx1) - (N+1)'(sx0);
					upd_y_q <= 1'b1;
					base_q  <= sy0;
				end else if ((sc0 & CODE_RIGHT) != '0) begin
					op_a_q  <= (N+1)'(wr_q) - (N+1)'(sx0);
					op_b_q  <= (N+1)'(sy1) - (N+1)'(sy0);
					op_c_q  <= (N+1)'(sx1) - (N+1)'(sx0);
					upd_y_q <= 1'b1;
					base_q  <= sy0;
				end else if ((sc0 & CODE_BOTTOM) != '0) begin
					op_a_q  <= (N+1)'(wb_q) - (N+1)'(sy0);
					op_b_q  <= (N+1)'(sx1) - (N+1)'(sx0);
					op_c_q  <= (N+1)'(sy1) - (N+1)'(sy0);
					upd_y_q <= 1'b0;
					base_q  <= sx0;
				end else begin
					op_a_q  <= (N+1)'(wt_q) - (N+1)'(sy0);
					op_b_q  <= (N+1)'(sx1) - (N+1)'(sx0);
					op_c_q  <= (N+1)'(sy1) - (N+1)'(sy0);
					upd_y_q <= 1'b0;
					base_q  <= sx0;
				end
			end
			ST_MUL: begin
				prod_q <= mag_a * mag_b;
				den_q  <= mag_c;
			end
			ST_DIV: begin
				// The edge coordinate is the window value the edge difference
				// was taken from: edge = op_a + point.
				if (done_ctl.vld) begin
					if (upd_y_q) begin
						x0_q <= x0_q + signed'(op_a_q[N-1:0]);
						y0_q <= new_coord;
					end else begin
						y0_q <= y0_q + signed'(op_a_q[N-1:0]);
						x0_q <= new_coord;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			vis_q <= vis_d;
			ofx_q <= x0_q;
			ofy_q <= y0_q;
			osx_q <= x1_q;
			osy_q <= y1_q;
		end
	end

	assign seg_stall    = (state_q != ST_IDLE);
	assign res_valid    = res_valid_q;
	assign visible      = vis_q;
	assign out_first_x  = ofx_q;
	assign out_first_y  = ofy_q;
	assign out_second_x = osx_q;
	assign out_second_y = osy_q;

	// A divider result only ever arrives while the sequencer waits for it.
	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		done_ctl.vld |-> state_q == ST_DIV)
		else $error("divider result outside the wait state");

	// The round count never passes the limit.
	a_round_limit: assert property (@(posedge clk) disable iff (!arst_n)
		round_q <= RW'(MAX_CLIP_ROUNDS))
		else $error("clip round count beyond limit");

	// A new result is only raised from the output state.
	a_res_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside the output state");

	// While idle, no item enters the divider chain and none leaves it.
	a_idle_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !start_q.vld && !done_ctl.vld)
		else $error("divider busy while idle");

endmodule
